/* src/clutch_position_window_and_command_macros.svh */
// ----------------------------------------------------------------------------
// Clutch position window and command: assertion macros
// Shared assertion forms, all clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLUTCH_POSITION_WINDOW_AND_COMMAND_MACROS_SVH
`define CLUTCH_POSITION_WINDOW_AND_COMMAND_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPWC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPWC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/cpwc_pkg.sv */
// ----------------------------------------------------------------------------
// Clutch position window and command: shared package
// Types, register indexes, command modes and reset constants of the block.
// ----------------------------------------------------------------------------
package cpwc_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CMD_BITS       = 16;
	localparam int SPEED_BITS     = 11;
	localparam int MODE_BITS      = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] REG_ENGAGED    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DISENGAGED = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BITE       = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MOVE_SPEED = 3'd4;

	// Item modes.
	localparam logic [MODE_BITS-1:0] MODE_SAMPLE  = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_COUNTS  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_PULL    = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_RELEASE = 2'd3;

	// Reset calibration, given at the widest position size and cut down on use.
	localparam logic [CMD_BITS-1:0]   ENGAGED_RESET    = 16'd7645;
	localparam logic [CMD_BITS-1:0]   DISENGAGED_RESET = 16'd24939;
	localparam logic [CMD_BITS-1:0]   TRIGGER_RESET    = 16'd18021;
	localparam logic [CMD_BITS-1:0]   BITE_RESET       = 16'd11103;
	localparam logic [SPEED_BITS-1:0] MOVE_SPEED_RESET = 11'd256;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_CMD,
		S_WAIT,
		S_OUT
	} cpwc_state_t;

	typedef struct packed {
		logic start;
	} cpwc_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cpwc_div_stat_t;

endpackage

/* src/cpwc_divider.sv */
// ----------------------------------------------------------------------------
// Clutch position window and command: fraction divider
// Restoring divider that forms (num << FRACTION_BITS) / den, one bit a cycle,
// for a numerator known to be below the denominator.
// ----------------------------------------------------------------------------
module cpwc_divider import cpwc_pkg::*; #(
	parameter int POSITION_BITS = 15,
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cpwc_div_ctl_t            ctl,
	input  logic [POSITION_BITS-1:0] num,
	input  logic [POSITION_BITS-1:0] den,
	output cpwc_div_stat_t           stat,
	output logic [FRACTION_BITS-1:0] quot
);

	localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

	logic [POSITION_BITS-1:0] rem_q;
	logic [POSITION_BITS-1:0] den_q;
	logic [FRACTION_BITS-1:0] quot_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic [POSITION_BITS:0]   shifted;
	logic                     fits;
	logic [POSITION_BITS:0]   diff;

	// The remainder stays below the divisor, so the doubled value fits one extra bit.
	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_BITS'(FRACTION_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[POSITION_BITS-1:0] : shifted[POSITION_BITS-1:0];
			quot_q <= {quot_q[FRACTION_BITS-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

/* src/clutch_position_window_and_command.sv */
// ----------------------------------------------------------------------------
// Clutch position window and command
// Classifies servo position samples against the clutch calibration, forms the
// pull fraction and keeps the last commanded servo position.
// ----------------------------------------------------------------------------
// Usage: each input beat (in_valid, in_stall) carries a mode, a position
// sample, a feedback flag and command arguments. For every input beat the
// block returns exactly one output beat (out_valid, out_stall) with the window
// flags, the pull fraction, the held commanded position and, when the beat
// issued a command, the move speed.
// Calibration registers are written over the cfg channel; cfg_ready is high
// only while no item is in work.
// Sequence: an accepted item passes the calculate and command states; an item
// whose fraction needs the divider then waits while the bit-serial fraction
// divider forms it, one quotient bit a cycle, and the result shows after the
// divider is done. An item whose fraction is zero or full skips the divider.
// The block accepts no new item until the result beat of the last is taken.
// While out_stall is high the result is held and no new item is accepted.
// Reset loads the calibration defaults and sets the commanded position to the
// engaged count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "clutch_position_window_and_command_macros.svh"

module clutch_position_window_and_command import cpwc_pkg::*; #(
	parameter int POSITION_BITS = 15,
	parameter int FRACTION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [MODE_BITS-1:0]      mode,
	input  logic [POSITION_BITS-1:0]  position,
	input  logic                      feedback_ok,
	input  logic [CMD_BITS-1:0]       command_counts,
	input  logic [FRACTION_BITS:0]    pull_request,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      disengaged,
	output logic                      just_engaged,
	output logic [FRACTION_BITS:0]    pull_fraction,
	output logic [POSITION_BITS-1:0]  commanded_counts,
	output logic                      command_issued,
	output logic [SPEED_BITS-1:0]     speed_out
);

	localparam int PROD_BITS = POSITION_BITS + FRACTION_BITS + 1;
	localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	cpwc_state_t state_q, state_d;

	// Calibration registers
	logic [POSITION_BITS-1:0] engaged_q;
	logic [POSITION_BITS-1:0] disengaged_cal_q;
	logic [POSITION_BITS-1:0] trigger_q;
	logic [POSITION_BITS-1:0] bite_q;
	logic [SPEED_BITS-1:0]    move_speed_q;
	logic [POSITION_BITS-1:0] commanded_q;

	// Captured item
	logic [MODE_BITS-1:0]     mode_q;
	logic [POSITION_BITS-1:0] position_q;
	logic                     feedback_ok_q;
	logic [CMD_BITS-1:0]      command_q;
	logic [FRACTION_BITS:0]   request_q;

	// Result and work registers
	logic                     disengaged_q;
	logic                     just_engaged_q;
	logic [FRACTION_BITS:0]   pull_q;
	logic                     issued_q;
	logic [SPEED_BITS-1:0]    speed_q;
	logic [POSITION_BITS-1:0] offset_q;
	logic                     use_div_q;

	// Sequencer strobes
	logic capture_en;
	logic calc_en;
	logic cmd_en;
	logic div_take;

	cpwc_div_ctl_t            div_ctl;
	cpwc_div_stat_t           div_stat;
	logic [FRACTION_BITS-1:0] div_quot;

	// Calibration derived terms
	logic                     rise;
	logic [POSITION_BITS-1:0] span;
	logic                     past_trigger;
	logic                     past_bite;
	logic                     behind;
	logic [POSITION_BITS-1:0] num;
	logic                     span_zero;
	logic                     full;
	logic                     use_div_c;
	logic [FRACTION_BITS:0]   pull_c;
	logic [FRACTION_BITS:0]   request_c;
	logic [PROD_BITS-1:0]     product;

	// Command path
	logic [POSITION_BITS-1:0] pull_target;
	logic [CMD_BITS-1:0]      target;
	logic                     issue_c;
	logic [CMD_BITS-1:0]      lo_ext;
	logic [CMD_BITS-1:0]      hi_ext;
	logic [CMD_BITS-1:0]      clamped;
	logic                     cmd_in_travel;

	// ------------------------------------------------------------------
	// Classification and fraction set-up
	// ------------------------------------------------------------------
	assign rise = disengaged_cal_q >= engaged_q;
	assign span = rise ? (disengaged_cal_q - engaged_q) : (engaged_q - disengaged_cal_q);

	assign past_trigger = rise ? (position_q >= trigger_q) : (position_q <= trigger_q);
	assign past_bite    = rise ? (position_q >= bite_q) : (position_q <= bite_q);

	assign span_zero = span == '0;
	assign behind    = rise ? (position_q <= engaged_q) : (position_q >= engaged_q);
	assign num       = rise ? (position_q - engaged_q) : (engaged_q - position_q);
	assign full      = num >= span;
	assign use_div_c = !span_zero && !behind && !full;

	always_comb begin
		if (span_zero || behind) begin
			pull_c = '0;
		end else if (full) begin
			pull_c = FRAC_ONE;
		end else begin
			pull_c = '0;
		end
	end

	assign request_c = (request_q > FRAC_ONE) ? FRAC_ONE : request_q;
	assign product   = PROD_BITS'(span) * PROD_BITS'(request_c);

	// ------------------------------------------------------------------
	// Command target and clamp to travel
	// ------------------------------------------------------------------
	assign pull_target = rise ? (engaged_q + offset_q) : (engaged_q - offset_q);

	always_comb begin
		target  = CMD_BITS'(engaged_q);
		issue_c = 1'b1;
		case (mode_q)
			MODE_COUNTS: begin
				target = command_q;
			end
			MODE_PULL: begin
				target = CMD_BITS'(pull_target);
			end
			MODE_RELEASE: begin
				target = CMD_BITS'(engaged_q);
			end
			default: begin
				issue_c = 1'b0;
			end
		endcase
	end

	assign lo_ext = CMD_BITS'(rise ? engaged_q : disengaged_cal_q);
	assign hi_ext = CMD_BITS'(rise ? disengaged_cal_q : engaged_q);

	always_comb begin
		if (target < lo_ext) begin
			clamped = lo_ext;
		end else if (target > hi_ext) begin
			clamped = hi_ext;
		end else begin
			clamped = target;
		end
	end

	// ------------------------------------------------------------------
	// Fraction divider
	// ------------------------------------------------------------------
	cpwc_divider #(
		.POSITION_BITS(POSITION_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (div_ctl),
		.num   (num),
		.den   (span),
		.stat  (div_stat),
		.quot  (div_quot)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				state_d = S_CMD;
			end
			S_CMD: begin
				state_d = use_div_q ? S_WAIT : S_OUT;
			end
			S_WAIT: begin
				if (div_stat.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall      = state_q != S_IDLE;
		cfg_ready     = state_q == S_IDLE;
		out_valid     = state_q == S_OUT;
		capture_en    = (state_q == S_IDLE) && in_valid;
		calc_en       = state_q == S_CALC;
		cmd_en        = state_q == S_CMD;
		div_take      = (state_q == S_WAIT) && div_stat.done;
		div_ctl.start = (state_q == S_CALC) && use_div_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Calibration and commanded position
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engaged_q        <= ENGAGED_RESET[POSITION_BITS-1:0];
			disengaged_cal_q <= DISENGAGED_RESET[POSITION_BITS-1:0];
			trigger_q        <= TRIGGER_RESET[POSITION_BITS-1:0];
			bite_q           <= BITE_RESET[POSITION_BITS-1:0];
			move_speed_q     <= MOVE_SPEED_RESET;
			commanded_q      <= ENGAGED_RESET[POSITION_BITS-1:0];
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENGAGED:    engaged_q        <= cfg_data[POSITION_BITS-1:0];
					REG_DISENGAGED: disengaged_cal_q <= cfg_data[POSITION_BITS-1:0];
					REG_TRIGGER:    trigger_q        <= cfg_data[POSITION_BITS-1:0];
					REG_BITE:       bite_q           <= cfg_data[POSITION_BITS-1:0];
					REG_MOVE_SPEED: move_speed_q     <= cfg_data[SPEED_BITS-1:0];
					default: begin
					end
				endcase
			end
			if (cmd_en && issue_c) begin
				commanded_q <= clamped[POSITION_BITS-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Item capture and result registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (capture_en) begin
			mode_q        <= mode;
			position_q    <= position;
			feedback_ok_q <= feedback_ok;
			command_q     <= command_counts;
			request_q     <= pull_request;
		end
		if (calc_en) begin
			disengaged_q   <= feedback_ok_q && past_trigger;
			just_engaged_q <= feedback_ok_q && !past_trigger && past_bite;
			pull_q         <= pull_c;
			use_div_q      <= use_div_c;
			offset_q       <= product[FRACTION_BITS +: POSITION_BITS];
		end
		if (cmd_en) begin
			issued_q <= issue_c;
			speed_q  <= issue_c ? move_speed_q : '0;
		end
		if (div_take) begin
			pull_q <= {1'b0, div_quot};
		end
	end

	assign disengaged       = disengaged_q;
	assign just_engaged     = just_engaged_q;
	assign pull_fraction    = pull_q;
	assign commanded_counts = commanded_q;
	assign command_issued   = issued_q;
	assign speed_out        = speed_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Travel bounds are formed here apart from the clamp path.
	assign cmd_in_travel = rise
		? ((commanded_q >= engaged_q) && (commanded_q <= disengaged_cal_q))
		: ((commanded_q <= engaged_q) && (commanded_q >= disengaged_cal_q));

	`CPWC_ASSERT_SAME(a_window_exclusive, out_valid, !(disengaged_q && just_engaged_q), "window flags overlap")
	`CPWC_ASSERT_SAME(a_pull_in_range, out_valid, pull_q <= FRAC_ONE, "pull fraction above one")
	`CPWC_ASSERT_SAME(a_speed_only_on_issue, out_valid && !issued_q, speed_q == '0, "stray speed")
	`CPWC_ASSERT_SAME(a_div_start_free, div_ctl.start, !div_stat.busy, "divider started while busy")
	`CPWC_ASSERT_NEXT(a_div_runs, div_ctl.start, div_stat.busy && !div_stat.done, "divider idle")
	`CPWC_ASSERT_SAME(a_cmd_in_travel, out_valid && issued_q, cmd_in_travel, "command outside travel")

endmodule

/* sim/clutch_window_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clutch window checker
// Watches the calibration, input and output channels of the clutch position
// window block, predicts the result of every accepted input beat from its own
// copy of the calibration and the held command, and compares each result beat
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module clutch_window_checker import cpwc_pkg::*; #(
	parameter int POSITION_BITS = 15,
	parameter int FRACTION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,

	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [MODE_BITS-1:0]      mode,
	input  logic [POSITION_BITS-1:0]  position,
	input  logic                      feedback_ok,
	input  logic [CMD_BITS-1:0]       command_counts,
	input  logic [FRACTION_BITS:0]    pull_request,

	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic                      disengaged,
	input  logic                      just_engaged,
	input  logic [FRACTION_BITS:0]    pull_fraction,
	input  logic [POSITION_BITS-1:0]  commanded_counts,
	input  logic                      command_issued,
	input  logic [SPEED_BITS-1:0]     speed_out,

	output int                        mismatches,
	output int                        outstanding
);

	typedef struct packed {
		logic                     disengaged;
		logic                     just_engaged;
		logic [FRACTION_BITS:0]   pull_fraction;
		logic [POSITION_BITS-1:0] commanded_counts;
		logic                     command_issued;
		logic [SPEED_BITS-1:0]    speed_out;
	} window_beat_t;

	logic [POSITION_BITS-1:0] eng_cal;
	logic [POSITION_BITS-1:0] dis_cal;
	logic [POSITION_BITS-1:0] trig_cal;
	logic [POSITION_BITS-1:0] bite_cal;
	logic [SPEED_BITS-1:0]    speed_cal;
	logic [POSITION_BITS-1:0] held_counts;

	window_beat_t expected_beats[$];
	window_beat_t predicted;
	window_beat_t oldest;

	function automatic window_beat_t predict_beat(
		input logic [MODE_BITS-1:0]     md,
		input logic [POSITION_BITS-1:0] pos,
		input logic                     ok,
		input logic [CMD_BITS-1:0]      cmd,
		input logic [FRACTION_BITS:0]   req
	);
		window_beat_t    r;
		logic            rise;
		logic            past_trig;
		logic            at_bite;
		logic            issued;
		longint unsigned one;
		longint unsigned span;
		longint unsigned num;
		longint unsigned frac;
		longint unsigned rq;
		longint unsigned off;
		longint unsigned target;
		longint unsigned lo;
		longint unsigned hi;

		one  = 64'd1 << FRACTION_BITS;
		rise = dis_cal >= eng_cal;
		span = rise ? longint'(dis_cal) - longint'(eng_cal)
			: longint'(eng_cal) - longint'(dis_cal);

		// Thresholds are reached moving toward the disengaged end, whichever way
		// the counts run.
		past_trig = rise ? (pos >= trig_cal) : (pos <= trig_cal);
		at_bite   = rise ? (pos >= bite_cal) : (pos <= bite_cal);
		r.disengaged   = ok & past_trig;
		r.just_engaged = ok & ~past_trig & at_bite;

		num = 0;
		if (rise && pos > eng_cal) begin
			num = longint'(pos) - longint'(eng_cal);
		end else if (!rise && pos < eng_cal) begin
			num = longint'(eng_cal) - longint'(pos);
		end
		if (span == 0 || num == 0)
			frac = 0;
		else if (num >= span)
			frac = one;
		else
			frac = (num << FRACTION_BITS) / span;
		r.pull_fraction = frac[FRACTION_BITS:0];

		issued = 1'b1;
		target = held_counts;
		case (md)
			MODE_COUNTS: target = cmd;
			MODE_PULL: begin
				rq     = (req > one) ? one : longint'(req);
				off    = (span * rq) >> FRACTION_BITS;
				target = rise ? longint'(eng_cal) + off : longint'(eng_cal) - off;
			end
			MODE_RELEASE: target = eng_cal;
			default: issued = 1'b0;
		endcase

		lo = rise ? eng_cal : dis_cal;
		hi = rise ? dis_cal : eng_cal;
		if (issued) begin
			if (target < lo)
				target = lo;
			else if (target > hi)
				target = hi;
		end
		r.commanded_counts = target[POSITION_BITS-1:0];
		r.command_issued   = issued;
		r.speed_out        = issued ? speed_cal : '0;
		return r;
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_cal     = ENGAGED_RESET[POSITION_BITS-1:0];
			dis_cal     = DISENGAGED_RESET[POSITION_BITS-1:0];
			trig_cal    = TRIGGER_RESET[POSITION_BITS-1:0];
			bite_cal    = BITE_RESET[POSITION_BITS-1:0];
			speed_cal   = MOVE_SPEED_RESET;
			held_counts = ENGAGED_RESET[POSITION_BITS-1:0];
			expected_beats.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					$error("result beat with no prediction waiting");
					mismatches++;
				end else begin
					oldest = expected_beats.pop_front();
					check_field("disengaged", oldest.disengaged, disengaged);
					check_field("just_engaged", oldest.just_engaged, just_engaged);
					check_field("pull_fraction", oldest.pull_fraction, pull_fraction);
					check_field("commanded_counts", oldest.commanded_counts,
						commanded_counts);
					check_field("command_issued", oldest.command_issued, command_issued);
					check_field("speed_out", oldest.speed_out, speed_out);
				end
			end

			if (in_valid && !in_stall) begin
				predicted   = predict_beat(mode, position, feedback_ok, command_counts,
					pull_request);
				held_counts = predicted.commanded_counts;
				expected_beats.push_back(predicted);
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENGAGED:    eng_cal   = cfg_data[POSITION_BITS-1:0];
					REG_DISENGAGED: dis_cal   = cfg_data[POSITION_BITS-1:0];
					REG_TRIGGER:    trig_cal  = cfg_data[POSITION_BITS-1:0];
					REG_BITE:       bite_cal  = cfg_data[POSITION_BITS-1:0];
					REG_MOVE_SPEED: speed_cal = cfg_data[SPEED_BITS-1:0];
					default: ;
				endcase
			end

			outstanding = expected_beats.size();
		end
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clutch position window and command testbench
// Drives position samples and commands under a series of calibrations (rising
// and falling travel, zero span, full travel, crossed thresholds and random
// sets) with random idling on both channels; the checker predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module testbench import cpwc_pkg::*;;

	localparam int POSITION_BITS = 15;
	localparam int FRACTION_BITS = 16;
	localparam int REQ_BITS      = FRACTION_BITS + 1;
	localparam int PERIOD        = 20;
	localparam int LATENCY       = FRACTION_BITS + 4;
	localparam int TIMEOUT_NS    = 10_000_000;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic [MODE_BITS-1:0]      mode;
	logic [POSITION_BITS-1:0]  position;
	logic                      feedback_ok;
	logic [CMD_BITS-1:0]       command_counts;
	logic [FRACTION_BITS:0]    pull_request;
	logic                      out_valid;
	logic                      out_stall;
	logic                      disengaged;
	logic                      just_engaged;
	logic [FRACTION_BITS:0]    pull_fraction;
	logic [POSITION_BITS-1:0]  commanded_counts;
	logic                      command_issued;
	logic [SPEED_BITS-1:0]     speed_out;
	int                        mismatches;
	int                        outstanding;

	// Stimulus-side copy of the calibration, used to aim samples at thresholds.
	logic [POSITION_BITS-1:0] cal_eng  = ENGAGED_RESET[POSITION_BITS-1:0];
	logic [POSITION_BITS-1:0] cal_dis  = DISENGAGED_RESET[POSITION_BITS-1:0];
	logic [POSITION_BITS-1:0] cal_trig = TRIGGER_RESET[POSITION_BITS-1:0];
	logic [POSITION_BITS-1:0] cal_bite = BITE_RESET[POSITION_BITS-1:0];
	int                       gap_pct  = 25;
	logic                     quiet_tail = 1'b0;

	always #(PERIOD / 2) clk = ~clk;

	clutch_position_window_and_command #(
		.POSITION_BITS(POSITION_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .position(position), .feedback_ok(feedback_ok),
		.command_counts(command_counts), .pull_request(pull_request),
		.out_valid(out_valid), .out_stall(out_stall),
		.disengaged(disengaged), .just_engaged(just_engaged),
		.pull_fraction(pull_fraction), .commanded_counts(commanded_counts),
		.command_issued(command_issued), .speed_out(speed_out)
	);

	clutch_window_checker #(
		.POSITION_BITS(POSITION_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .position(position), .feedback_ok(feedback_ok),
		.command_counts(command_counts), .pull_request(pull_request),
		.out_valid(out_valid), .out_stall(out_stall),
		.disengaged(disengaged), .just_engaged(just_engaged),
		.pull_fraction(pull_fraction), .commanded_counts(commanded_counts),
		.command_issued(command_issued), .speed_out(speed_out),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// Result side: random stall bursts, with calm stretches between.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet_tail) begin
				if ($urandom_range(0, 7) == 0) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 14)) @(negedge clk);
					out_stall <= 1'b0;
				end else if ($urandom_range(0, 19) == 0) begin
					repeat ($urandom_range(20, 80)) @(negedge clk);
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("testbench NOT OK");
		$finish;
	end

	function automatic logic [POSITION_BITS-1:0] near_count(
		input logic [POSITION_BITS-1:0] base);
		int n;
		n = int'(base) + int'($urandom_range(0, 6)) - 3;
		if (n < 0)
			n = 0;
		if (n > (1 << POSITION_BITS) - 1)
			n = (1 << POSITION_BITS) - 1;
		return n[POSITION_BITS-1:0];
	endfunction

	// Every task is entered and left just after a falling edge.
	task automatic send_item(
		input logic [MODE_BITS-1:0]     md,
		input logic [POSITION_BITS-1:0] pos,
		input logic                     ok,
		input logic [CMD_BITS-1:0]      cmd,
		input logic [FRACTION_BITS:0]   req
	);
		if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		mode           <= md;
		position       <= pos;
		feedback_ok    <= ok;
		command_counts <= cmd;
		pull_request   <= req;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random_item();
		logic [MODE_BITS-1:0]     md;
		logic [POSITION_BITS-1:0] pos;
		logic                     ok;
		logic [CMD_BITS-1:0]      cmd;
		logic [FRACTION_BITS:0]   req;

		md = MODE_BITS'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			4: pos = near_count(cal_eng);
			5: pos = near_count(cal_dis);
			6: pos = near_count(cal_trig);
			7: pos = near_count(cal_bite);
			8: pos = $urandom_range(0, 1) ? '1 : '0;
			default: pos = POSITION_BITS'($urandom);
		endcase
		ok = $urandom_range(0, 3) != 0;
		case ($urandom_range(0, 5))
			0: cmd = '0;
			1: cmd = '1;
			2: cmd = {1'b0, near_count($urandom_range(0, 1) ? cal_eng : cal_dis)};
			default: cmd = CMD_BITS'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: req = '0;
			1: req = 17'd65536;
			2: req = REQ_BITS'($urandom_range(65537, 131071));
			default: req = REQ_BITS'($urandom_range(0, 65536));
		endcase
		send_item(md, pos, ok, cmd, req);
	endtask

	task automatic send_random_items(input int count);
		repeat (count) send_random_item();
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_calibration(
		input logic [CFG_DATA_BITS-1:0] eng,
		input logic [CFG_DATA_BITS-1:0] dis,
		input logic [CFG_DATA_BITS-1:0] trig,
		input logic [CFG_DATA_BITS-1:0] bite,
		input logic [CFG_DATA_BITS-1:0] speed
	);
		hold_until_drained();
		// An index past the register list must leave the calibration alone.
		write_reg(REG_MOVE_SPEED + CFG_INDEX_BITS'($urandom_range(1, 3)),
			CFG_DATA_BITS'($urandom));
		write_reg(REG_ENGAGED, eng);
		write_reg(REG_DISENGAGED, dis);
		write_reg(REG_TRIGGER, trig);
		write_reg(REG_BITE, bite);
		write_reg(REG_MOVE_SPEED, speed);
		cfg_valid <= 1'b0;
		cal_eng  = eng[POSITION_BITS-1:0];
		cal_dis  = dis[POSITION_BITS-1:0];
		cal_trig = trig[POSITION_BITS-1:0];
		cal_bite = bite[POSITION_BITS-1:0];
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		mode           = MODE_SAMPLE;
		position       = '0;
		feedback_ok    = 1'b0;
		command_counts = '0;
		pull_request   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset calibration: window edges, clamps and pull corners.
		send_item(MODE_SAMPLE, '0, 1'b1, '0, '0);
		send_item(MODE_SAMPLE, '1, 1'b1, '1, '1);
		send_item(MODE_SAMPLE, cal_eng, 1'b1, '0, '0);
		send_item(MODE_SAMPLE, cal_eng + 1'b1, 1'b1, '0, '0);
		send_item(MODE_SAMPLE, cal_dis, 1'b1, '0, '0);
		send_item(MODE_SAMPLE, cal_dis - 1'b1, 1'b1, '0, '0);
		send_item(MODE_SAMPLE, cal_trig, 1'b1, '0, '0);
		send_item(MODE_SAMPLE, cal_trig - 1'b1, 1'b1, '0, '0);
		send_item(MODE_SAMPLE, cal_bite, 1'b1, '0, '0);
		send_item(MODE_SAMPLE, cal_bite - 1'b1, 1'b1, '0, '0);
		send_item(MODE_SAMPLE, 15'd15000, 1'b0, '0, '0);
		send_item(MODE_SAMPLE, cal_trig, 1'b0, '0, '0);
		send_item(MODE_COUNTS, 15'd9000, 1'b1, '0, '0);
		send_item(MODE_COUNTS, 15'd20000, 1'b1, '1, '0);
		send_item(MODE_COUNTS, 15'd12000, 1'b1, 16'd12345, '0);
		send_item(MODE_PULL, 15'd3000, 1'b1, '0, '0);
		send_item(MODE_PULL, 15'd30000, 1'b1, '0, 17'd65536);
		send_item(MODE_PULL, 15'd8000, 1'b0, '0, '1);
		send_item(MODE_PULL, 15'd16000, 1'b1, '0, 17'd32768);
		send_item(MODE_PULL, 15'd16000, 1'b1, '0, 17'd1);
		send_item(MODE_RELEASE, 15'd24000, 1'b1, '1, '1);
		send_item(MODE_SAMPLE, 15'd11000, 1'b1, '0, '0);
		send_random_items(40);
		hold_until_drained();
		send_random_items(40);

		gap_pct = 0;
		set_calibration(16'd3000, 16'd29000, 16'd20000, 16'd9000, 16'd1280);
		send_random_items(90);

		gap_pct = 30;
		set_calibration(16'd26000, 16'd5000, 16'd12000, 16'd21000, 16'd0);
		send_random_items(90);

		// Zero span: no fraction, and every command lands on the engaged count.
		gap_pct = 15;
		set_calibration(16'd15000, 16'd15000, 16'd15000, 16'd15000, 16'd777);
		send_item(MODE_PULL, 15'd15001, 1'b1, '0, 17'd65536);
		send_item(MODE_COUNTS, 15'd14999, 1'b1, '1, '0);
		send_item(MODE_SAMPLE, 15'd15000, 1'b1, '0, '0);
		send_random_items(60);

		gap_pct = 40;
		set_calibration(16'd0, 16'd32767, 16'd32767, 16'd0, 16'd1);
		send_random_items(80);

		gap_pct = 0;
		set_calibration(16'd32767, 16'd0, 16'd0, 16'd32767, 16'hF800 | 16'd1280);
		send_random_items(80);

		// Trigger beyond the disengaged end and bite beyond the trigger.
		gap_pct = 25;
		set_calibration(16'd10000, 16'd20000, 16'd25000, 16'd30000, 16'd512);
		send_random_items(80);

		repeat (3) begin
			gap_pct = $urandom_range(0, 40);
			set_calibration(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
				CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
				CFG_DATA_BITS'($urandom_range(0, 1280)));
			send_random_items(60);
		end

		set_calibration(16'd7645, 16'd24939, 16'd18021, 16'd11103, 16'd256);
		quiet_tail = 1'b1;
		send_random_items(80);

		hold_until_drained();
		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
